@@ hw/rtl/stroke_proximity_hit_test_unit_macros.svh @@
// Assertion helpers shared by the RTL modules.
// Both macros expect clk_i and rst_ni in the scope where they are used.
`ifndef STROKE_PROXIMITY_HIT_TEST_UNIT_MACROS_SVH
`define STROKE_PROXIMITY_HIT_TEST_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define SPHTU_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: property failed");
`define SPHTU_ASSERT_NEVER(label, expr) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("%m: forbidden condition seen");
`else
`define SPHTU_ASSERT(label, prop)
`define SPHTU_ASSERT_NEVER(label, expr)
`endif
`endif

@@ hw/rtl/sphtu_pkg.sv @@
package sphtu_pkg;

  // default coordinate code width (signed fixed point, raw codes)
  localparam int unsigned COORD_BITS_DEF = 24;

  // entries in the queue between classifier and evaluator
  localparam int unsigned QUEUE_DEPTH = 2;

  // APB register window
  localparam int unsigned APB_ADDR_BITS = 4;
  localparam int unsigned APB_DATA_BITS = 32;

  // register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_QUERY_X       = 2'd0,
    REG_QUERY_Y       = 2'd1,
    REG_SEARCH_RADIUS = 2'd2
  } reg_idx_e;

  // per-segment control carried alongside the operand vector
  typedef struct packed {
    logic last;    // closes the stroke, a result is due
    logic single;  // stroke of one point, tested against the point itself
  } item_ctrl_t;

  // operand vector: six (coord+1)-bit differences and one coord-bit threshold
  function automatic int unsigned item_bits(int unsigned coord_bits);
    return 7 * coord_bits + 6;
  endfunction

endpackage

@@ hw/rtl/sphtu_front.sv @@
`include "stroke_proximity_hit_test_unit_macros.svh"

module sphtu_front #(
  parameter int unsigned COORD_BITS = sphtu_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  // point stream
  input  logic                                           in_valid_i,
  output logic                                           in_ready_o,
  input  logic signed [COORD_BITS-1:0]                   point_x_i,
  input  logic signed [COORD_BITS-1:0]                   point_y_i,
  input  logic [COORD_BITS-2:0]                          stroke_width_i,
  input  logic                                           last_point_i,
  // configuration
  input  logic signed [COORD_BITS-1:0]                   query_x_i,
  input  logic signed [COORD_BITS-1:0]                   query_y_i,
  input  logic [COORD_BITS-2:0]                          search_radius_i,
  // queue write side
  output logic                                           push_o,
  output logic [sphtu_pkg::item_bits(COORD_BITS)-1:0]    push_data_o,
  output sphtu_pkg::item_ctrl_t                          push_ctrl_o,
  input  logic                                           q_full_i
);

  localparam int unsigned SW = COORD_BITS + 1;

  logic signed [COORD_BITS-1:0] prev_x_q, prev_y_q;
  logic                         have_prev_q;
  logic                         accept;
  logic signed [SW-1:0]         px, py, ax, ay, qx, qy;
  logic signed [SW-1:0]         ux, uy, vx, vy, dx, dy;
  logic [COORD_BITS-1:0]        thr;

  // handshake: every point is taken while the queue has room
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // segment start: previous point, or the point itself for a lone point
  assign px = SW'(point_x_i);
  assign py = SW'(point_y_i);
  assign ax = have_prev_q ? SW'(prev_x_q) : px;
  assign ay = have_prev_q ? SW'(prev_y_q) : py;
  assign qx = SW'(query_x_i);
  assign qy = SW'(query_y_i);

  // differences: start to query, end to query, start to end
  assign ux = qx - ax;
  assign uy = qy - ay;
  assign vx = qx - px;
  assign vy = qy - py;
  assign dx = px - ax;
  assign dy = py - ay;

  // threshold: radius plus half the width, truncated
  assign thr = COORD_BITS'(search_radius_i) + COORD_BITS'(stroke_width_i >> 1);

  // a first point that is not last only gets stored
  assign push_o             = accept && (have_prev_q || last_point_i);
  assign push_data_o        = {thr, dy, dx, vy, vx, uy, ux};
  assign push_ctrl_o.last   = last_point_i;
  assign push_ctrl_o.single = !have_prev_q;

  // stroke tracking
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      have_prev_q <= 1'b0;
    end else if (accept) begin
      if (last_point_i) begin
        prev_x_q    <= '0;
        prev_y_q    <= '0;
        have_prev_q <= 1'b0;
      end else begin
        prev_x_q    <= point_x_i;
        prev_y_q    <= point_y_i;
        have_prev_q <= 1'b1;
      end
    end
  end

  // a stroke stays open exactly until its last point is taken
  `SPHTU_ASSERT(a_stroke_tracking, (in_valid_i && in_ready_o) |=> (have_prev_q == !$past(last_point_i)))

endmodule

@@ hw/rtl/sphtu_queue.sv @@
`include "stroke_proximity_hit_test_unit_macros.svh"

module sphtu_queue #(
  parameter int unsigned COORD_BITS = sphtu_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           push_i,
  input  logic [sphtu_pkg::item_bits(COORD_BITS)-1:0]    push_data_i,
  input  sphtu_pkg::item_ctrl_t                          push_ctrl_i,
  output logic                                           full_o,
  input  logic                                           pop_i,
  output logic                                           valid_o,
  output logic [sphtu_pkg::item_bits(COORD_BITS)-1:0]    pop_data_o,
  output sphtu_pkg::item_ctrl_t                          pop_ctrl_o
);

  localparam int unsigned DW    = sphtu_pkg::item_bits(COORD_BITS);
  localparam int unsigned DEPTH = sphtu_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DW-1:0]         data_q [DEPTH];
  sphtu_pkg::item_ctrl_t ctrl_q [DEPTH];
  logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]      count_q;

  assign full_o     = (count_q == CNT_W'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_data_o = data_q[rd_ptr_q];
  assign pop_ctrl_o = ctrl_q[rd_ptr_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      data_q[wr_ptr_q] <= push_data_i;
      ctrl_q[wr_ptr_q] <= push_ctrl_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `SPHTU_ASSERT_NEVER(a_no_overflow, push_i && (count_q == CNT_W'(DEPTH)) && !pop_i)
  `SPHTU_ASSERT_NEVER(a_no_underflow, pop_i && (count_q == '0))

endmodule

@@ hw/rtl/sphtu_back.sv @@
`include "stroke_proximity_hit_test_unit_macros.svh"

module sphtu_back #(
  parameter int unsigned COORD_BITS = sphtu_pkg::COORD_BITS_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  // queue read side
  input  logic                                           q_valid_i,
  input  logic [sphtu_pkg::item_bits(COORD_BITS)-1:0]    q_data_i,
  input  sphtu_pkg::item_ctrl_t                          q_ctrl_i,
  output logic                                           pop_o,
  // result stream
  output logic                                           out_valid_o,
  input  logic                                           out_ready_i,
  output logic                                           hit_o
);

  localparam int unsigned SW    = COORD_BITS + 1;       // signed difference
  localparam int unsigned MW    = COORD_BITS + 1;       // multiplier operand
  localparam int unsigned PW    = 2 * MW;               // multiplier product
  localparam int unsigned HW    = 2 * COORD_BITS + 1;   // wide magnitudes (cross, len2)
  localparam int unsigned TW    = 2 * COORD_BITS;       // squared threshold
  localparam int unsigned AW    = 4 * COORD_BITS + 3;   // accumulator
  localparam int unsigned NOPS  = 6;
  localparam int unsigned CNT_W = 3;

  // operand slots, in the order the classifier packs them
  localparam int unsigned IX_UX = 0;
  localparam int unsigned IX_UY = 1;
  localparam int unsigned IX_VX = 2;
  localparam int unsigned IX_VY = 3;
  localparam int unsigned IX_DX = 4;
  localparam int unsigned IX_DY = 5;

  // sequencer states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  // evaluation phases
  localparam logic [2:0] PH_T2    = 3'd0;  // t*t
  localparam logic [2:0] PH_DOTA  = 3'd1;  // u.d
  localparam logic [2:0] PH_DOTB  = 3'd2;  // v.d
  localparam logic [2:0] PH_CROSS = 3'd3;  // u x d
  localparam logic [2:0] PH_LEN   = 3'd4;  // d.d
  localparam logic [2:0] PH_CMP   = 3'd5;  // t2*len2 - cross^2
  localparam logic [2:0] PH_NEARU = 3'd6;  // t2 - |u|^2
  localparam logic [2:0] PH_NEARV = 3'd7;  // t2 - |v|^2

  // partial product alignment
  localparam logic [1:0] SH_0 = 2'd0;
  localparam logic [1:0] SH_1 = 2'd1;
  localparam logic [1:0] SH_2 = 2'd2;

  logic [1:0]            state_q, state_d;
  logic [2:0]            phase_q, phase_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d, cnt_last;
  logic                  load;

  logic [SW-1:0]         fld   [NOPS];
  logic [MW-1:0]         mag_w [NOPS];
  logic                  sgn_w [NOPS];
  logic [MW-1:0]         mag_q [NOPS];
  logic                  sgn_q [NOPS];
  logic [MW-1:0]         t_q;
  sphtu_pkg::item_ctrl_t ctrl_q;

  logic [TW-1:0]         t2_q, t2_d;
  logic [HW-1:0]         l2_q, l2_d, cm_q, cm_d;
  logic [HW-1:0]         big_x, big_y;

  logic [MW-1:0]         opa, opb;
  logic                  ineg;
  logic [1:0]            ish;
  logic [PW-1:0]         prod_q, prod_d;
  logic                  pneg_q, pv_q, pv_d;
  logic [1:0]            psh_q;

  logic signed [AW-1:0]  acc_q, acc_d, acc_sum, acc_shift, acc_add, acc_abs;
  logic                  acc_le0, seg_hit;

  logic                  hit_so_far_q, hit_so_far_d;
  logic                  out_valid_q, out_valid_d, hit_q, hit_d;

  assign pop_o       = (state_q == ST_IDLE) && q_valid_i;
  assign load        = pop_o;
  assign out_valid_o = out_valid_q;
  assign hit_o       = hit_q;

  // magnitudes and signs of the incoming differences
  always_comb begin
    for (int i = 0; i < NOPS; i++) begin
      fld[i]   = q_data_i[i*SW +: SW];
      sgn_w[i] = fld[i][SW-1];
      mag_w[i] = fld[i][SW-1] ? MW'(-fld[i]) : MW'(fld[i]);
    end
  end

  // wide operands for the final comparison, split into halves
  assign big_x = cnt_q[2] ? cm_q : HW'(t2_q);
  assign big_y = cnt_q[2] ? cm_q : l2_q;

  // number of products per phase, minus one
  always_comb begin
    case (phase_q)
      PH_T2:   cnt_last = CNT_W'(0);
      PH_CMP:  cnt_last = CNT_W'(7);
      default: cnt_last = CNT_W'(1);
    endcase
  end

  // operand selection for the shared multiplier
  always_comb begin
    opa  = '0;
    opb  = '0;
    ineg = 1'b0;
    ish  = SH_0;
    case (phase_q)
      PH_T2: begin
        opa = t_q;
        opb = t_q;
      end
      PH_DOTA: begin
        if (cnt_q[0]) begin
          opa  = mag_q[IX_UY];
          opb  = mag_q[IX_DY];
          ineg = sgn_q[IX_UY] ^ sgn_q[IX_DY];
        end else begin
          opa  = mag_q[IX_UX];
          opb  = mag_q[IX_DX];
          ineg = sgn_q[IX_UX] ^ sgn_q[IX_DX];
        end
      end
      PH_DOTB: begin
        if (cnt_q[0]) begin
          opa  = mag_q[IX_VY];
          opb  = mag_q[IX_DY];
          ineg = sgn_q[IX_VY] ^ sgn_q[IX_DY];
        end else begin
          opa  = mag_q[IX_VX];
          opb  = mag_q[IX_DX];
          ineg = sgn_q[IX_VX] ^ sgn_q[IX_DX];
        end
      end
      PH_CROSS: begin
        if (cnt_q[0]) begin
          opa  = mag_q[IX_UY];
          opb  = mag_q[IX_DX];
          ineg = !(sgn_q[IX_UY] ^ sgn_q[IX_DX]);
        end else begin
          opa  = mag_q[IX_UX];
          opb  = mag_q[IX_DY];
          ineg = sgn_q[IX_UX] ^ sgn_q[IX_DY];
        end
      end
      PH_LEN: begin
        opa = cnt_q[0] ? mag_q[IX_DY] : mag_q[IX_DX];
        opb = opa;
      end
      PH_CMP: begin
        // four partials of t2*len2 added, then four of cross^2 subtracted
        opa  = cnt_q[1] ? MW'(big_x[HW-1:MW]) : big_x[MW-1:0];
        opb  = cnt_q[0] ? MW'(big_y[HW-1:MW]) : big_y[MW-1:0];
        ineg = cnt_q[2];
        ish  = (cnt_q[1:0] == 2'b00) ? SH_0 : ((cnt_q[1:0] == 2'b11) ? SH_2 : SH_1);
      end
      PH_NEARU: begin
        opa  = cnt_q[0] ? mag_q[IX_UY] : mag_q[IX_UX];
        opb  = opa;
        ineg = 1'b1;
      end
      PH_NEARV: begin
        opa  = cnt_q[0] ? mag_q[IX_VY] : mag_q[IX_VX];
        opb  = opa;
        ineg = 1'b1;
      end
      default: begin
        opa = '0;
      end
    endcase
  end

  assign prod_d = PW'(opa) * PW'(opb);

  // accumulate the registered product at its alignment
  always_comb begin
    case (psh_q)
      SH_1:    acc_shift = AW'(prod_q) << MW;
      SH_2:    acc_shift = AW'(prod_q) << (2 * MW);
      default: acc_shift = AW'(prod_q);
    endcase
  end

  assign acc_add = pneg_q ? -acc_shift : acc_shift;
  assign acc_sum = pv_q ? acc_q + acc_add : acc_q;
  assign acc_abs = acc_sum[AW-1] ? -acc_sum : acc_sum;
  assign acc_le0 = acc_sum[AW-1] || (acc_sum == '0);
  assign seg_hit = !acc_sum[AW-1];

  // sequencer
  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    cnt_d        = cnt_q;
    pv_d         = 1'b0;
    acc_d        = acc_sum;
    t2_d         = t2_q;
    l2_d         = l2_q;
    cm_d         = cm_q;
    hit_so_far_d = hit_so_far_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    hit_d        = hit_q;
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          acc_d   = '0;
          phase_d = PH_T2;
          cnt_d   = '0;
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        pv_d = 1'b1;
        if (cnt_q == cnt_last) begin
          cnt_d   = '0;
          state_d = ST_DRAIN;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        // last product lands in acc_sum; pick the next phase
        state_d = ST_ISSUE;
        acc_d   = '0;
        case (phase_q)
          PH_T2: begin
            t2_d = acc_sum[TW-1:0];
            if (ctrl_q.single) begin
              phase_d = PH_NEARU;
              acc_d   = AW'(t2_d);
            end else begin
              phase_d = PH_DOTA;
            end
          end
          PH_DOTA: begin
            // query projects before the segment start
            if (acc_le0) begin
              phase_d = PH_NEARU;
              acc_d   = AW'(t2_q);
            end else begin
              phase_d = PH_DOTB;
            end
          end
          PH_DOTB: begin
            // query projects past the segment end
            if (!acc_sum[AW-1]) begin
              phase_d = PH_NEARV;
              acc_d   = AW'(t2_q);
            end else begin
              phase_d = PH_CROSS;
            end
          end
          PH_CROSS: begin
            cm_d    = acc_abs[HW-1:0];
            phase_d = PH_LEN;
          end
          PH_LEN: begin
            l2_d    = acc_sum[HW-1:0];
            phase_d = PH_CMP;
          end
          PH_CMP, PH_NEARU, PH_NEARV: begin
            // segment decided; hold here while the result slot is busy
            acc_d   = acc_sum;
            state_d = ST_DRAIN;
            if (!ctrl_q.last) begin
              hit_so_far_d = hit_so_far_q || seg_hit;
              state_d      = ST_IDLE;
            end else if (!out_valid_q || out_ready_i) begin
              out_valid_d  = 1'b1;
              hit_d        = hit_so_far_q || seg_hit;
              hit_so_far_d = 1'b0;
              state_d      = ST_IDLE;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      phase_q      <= PH_T2;
      cnt_q        <= '0;
      pv_q         <= 1'b0;
      hit_so_far_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      phase_q      <= phase_d;
      cnt_q        <= cnt_d;
      pv_q         <= pv_d;
      hit_so_far_q <= hit_so_far_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (load) begin
      for (int i = 0; i < NOPS; i++) begin
        mag_q[i] <= mag_w[i];
        sgn_q[i] <= sgn_w[i];
      end
      t_q    <= MW'(q_data_i[sphtu_pkg::item_bits(COORD_BITS)-1 -: COORD_BITS]);
      ctrl_q <= q_ctrl_i;
    end
    prod_q <= prod_d;
    pneg_q <= ineg;
    psh_q  <= ish;
    acc_q  <= acc_d;
    t2_q   <= t2_d;
    l2_q   <= l2_d;
    cm_q   <= cm_d;
    hit_q  <= hit_d;
  end

  `SPHTU_ASSERT(a_prod_in_flight, pv_q |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
  `SPHTU_ASSERT(a_result_src, $rose(out_valid_q) |-> $past(state_q == ST_DRAIN && phase_q >= PH_CMP))
  `SPHTU_ASSERT(a_flag_cleared, $rose(out_valid_q) |-> !hit_so_far_q)

endmodule

@@ hw/rtl/stroke_proximity_hit_test_unit.sv @@
// A lone-point stroke takes the shortest path through the evaluator; of the segment paths,
// the full clamp-and-compare path is the longest.
// The evaluator takes one segment at a time through the single shared (COORD_BITS+1)-bit
// multiplier that computes every product in turn.
// A 2-entry queue lets the point port keep accepting while a segment is evaluated.
// Reset (rst_ni, async, active low) clears stroke state, hit flag, result valid, config regs.
module stroke_proximity_hit_test_unit #(
  parameter int unsigned COORD_BITS = sphtu_pkg::COORD_BITS_DEF
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // point stream
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic signed [COORD_BITS-1:0]            point_x_i,
  input  logic signed [COORD_BITS-1:0]            point_y_i,
  input  logic [COORD_BITS-2:0]                   stroke_width_i,
  input  logic                                    last_point_i,
  // result stream
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic                                    hit_o,
  // APB configuration
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [sphtu_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [sphtu_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [sphtu_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                    pready
);

  localparam int unsigned DW = sphtu_pkg::item_bits(COORD_BITS);
  localparam int unsigned DB = sphtu_pkg::APB_DATA_BITS;
  localparam int unsigned AB = sphtu_pkg::APB_ADDR_BITS;

  logic signed [COORD_BITS-1:0] query_x_q, query_y_q;
  logic [COORD_BITS-2:0]        search_radius_q;
  logic [AB-3:0]                reg_sel;
  logic                         cfg_wr;

  logic                         push, q_full, q_valid, pop;
  logic [DW-1:0]                push_data, pop_data;
  sphtu_pkg::item_ctrl_t        push_ctrl, pop_ctrl;

  // register file
  assign pready  = 1'b1;
  assign reg_sel = paddr[AB-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q       <= '0;
      query_y_q       <= '0;
      search_radius_q <= '0;
    end else if (cfg_wr) begin
      case (reg_sel)
        sphtu_pkg::REG_QUERY_X:       query_x_q       <= pwdata[COORD_BITS-1:0];
        sphtu_pkg::REG_QUERY_Y:       query_y_q       <= pwdata[COORD_BITS-1:0];
        sphtu_pkg::REG_SEARCH_RADIUS: search_radius_q <= pwdata[COORD_BITS-2:0];
        default: begin
        end
      endcase
    end
  end

  // read back, query sign-extended
  always_comb begin
    case (reg_sel)
      sphtu_pkg::REG_QUERY_X:       prdata = DB'(query_x_q);
      sphtu_pkg::REG_QUERY_Y:       prdata = DB'(query_y_q);
      sphtu_pkg::REG_SEARCH_RADIUS: prdata = DB'(search_radius_q);
      default:                      prdata = '0;
    endcase
  end

  // classifier: stroke tracking and differences
  sphtu_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .stroke_width_i (stroke_width_i),
    .last_point_i   (last_point_i),
    .query_x_i      (query_x_q),
    .query_y_i      (query_y_q),
    .search_radius_i(search_radius_q),
    .push_o         (push),
    .push_data_o    (push_data),
    .push_ctrl_o    (push_ctrl),
    .q_full_i       (q_full)
  );

  // segment queue
  sphtu_queue #(
    .COORD_BITS(COORD_BITS)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .push_ctrl_i(push_ctrl),
    .full_o     (q_full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_data_o (pop_data),
    .pop_ctrl_o (pop_ctrl)
  );

  // evaluator: shared multiplier sequence and hit flag
  sphtu_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_data_i   (pop_data),
    .q_ctrl_i   (pop_ctrl),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .hit_o      (hit_o)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam int CW = sphtu_pkg::COORD_BITS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  // queue and evaluator together can hold up to three segments
  localparam int SETTLE_CYCLES = 100;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic [CW-2:0] width_t;
  typedef logic signed [127:0] wide_t;

  localparam coord_t CMAX = {1'b0, {(CW-1){1'b1}}};
  localparam coord_t CMIN = {1'b1, {(CW-1){1'b0}}};
  localparam width_t WMAX = '1;

  logic clk;
  logic rst_ni;
  logic in_valid;
  logic in_ready;
  coord_t pt_x;
  coord_t pt_y;
  width_t pt_width;
  logic pt_last;
  logic out_valid;
  logic rsp_ready;
  logic hit;
  logic psel;
  logic penable;
  logic pwrite;
  logic [sphtu_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [sphtu_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [sphtu_pkg::APB_DATA_BITS-1:0] prdata;
  logic pready;

  stroke_proximity_hit_test_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .point_x_i      (pt_x),
    .point_y_i      (pt_y),
    .stroke_width_i (pt_width),
    .last_point_i   (pt_last),
    .out_valid_o    (out_valid),
    .out_ready_i    (rsp_ready),
    .hit_o          (hit),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // shadow of the block: registers and open-stroke state
  longint cfg_qx, cfg_qy, cfg_radius;
  longint prev_px, prev_py;
  bit have_prev, hit_acc;
  bit hit_expected_q[$];

  int fail_count, n_points, n_strokes, n_writes, n_results, n_hits;
  int burst_left;
  int cycle_count;
  int stall_mode, stall_left;
  bit exp_hit;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, hit_expected_q.size());
      $display("simulation failed");
      $finish;
    end
  end

  // result checker and receiver stall pattern
  always @(posedge clk) begin
    if (out_valid === 1'b1 && rsp_ready) begin
      if (hit_expected_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual hit=%0b", $time, hit);
        fail_count++;
      end else begin
        exp_hit = hit_expected_q.pop_front();
        n_results++;
        if (exp_hit) n_hits++;
        if (hit !== exp_hit) begin
          $display("%0t: hit mismatch, expected %0b, actual %0b", $time, exp_hit, hit);
          fail_count++;
        end
      end
    end
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 64);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0: rsp_ready <= 1'b1;
      1: rsp_ready <= 1'($urandom_range(0, 1));
      default: rsp_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------- predictor ----------------

  function automatic wide_t wprod(longint a, longint b);
    return wide_t'(a) * wide_t'(b);
  endfunction

  function automatic bit near_point(longint ex, longint ey, wide_t t2);
    return (wprod(ex, ex) + wprod(ey, ey)) <= t2;
  endfunction

  // query point within thr of segment a-b, projection clamped to the segment
  function automatic bit segment_within(longint ax, longint ay, longint bx, longint by,
                                        longint thr);
    longint dx, dy, ux, uy, vx, vy;
    wide_t t2, dot_a, dot_b, perp, len2;
    dx = bx - ax;
    dy = by - ay;
    ux = cfg_qx - ax;
    uy = cfg_qy - ay;
    vx = cfg_qx - bx;
    vy = cfg_qy - by;
    t2 = wprod(thr, thr);
    dot_a = wprod(ux, dx) + wprod(uy, dy);
    if (dot_a <= 0) return near_point(ux, uy, t2);
    dot_b = wprod(vx, dx) + wprod(vy, dy);
    if (dot_b >= 0) return near_point(vx, vy, t2);
    perp = wprod(ux, dy) - wprod(uy, dx);
    len2 = wprod(dx, dx) + wprod(dy, dy);
    return (perp * perp) <= (t2 * len2);
  endfunction

  task automatic predict_point(coord_t x, coord_t y, width_t w, bit is_last);
    longint px, py, thr;
    px = longint'(x);
    py = longint'(y);
    thr = cfg_radius + longint'(w >> 1);
    if (have_prev) begin
      if (segment_within(prev_px, prev_py, px, py, thr)) hit_acc = 1'b1;
    end else if (is_last) begin
      if (segment_within(px, py, px, py, thr)) hit_acc = 1'b1;
    end
    prev_px = px;
    prev_py = py;
    have_prev = 1'b1;
    if (is_last) begin
      hit_expected_q = {hit_expected_q, hit_acc};
      prev_px = 0;
      prev_py = 0;
      have_prev = 1'b0;
      hit_acc = 1'b0;
      n_strokes++;
    end
  endtask

  // ---------------- drivers ----------------

  task automatic apb_write(sphtu_pkg::reg_idx_e idx, logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      sphtu_pkg::REG_QUERY_X: cfg_qx = longint'($signed(val[CW-1:0]));
      sphtu_pkg::REG_QUERY_Y: cfg_qy = longint'($signed(val[CW-1:0]));
      sphtu_pkg::REG_SEARCH_RADIUS: cfg_radius = longint'(val[CW-2:0]);
      default: ;
    endcase
    n_writes++;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(coord_t qx, coord_t qy, width_t radius);
    apb_write(sphtu_pkg::REG_QUERY_X, 32'(qx));
    apb_write(sphtu_pkg::REG_QUERY_Y, 32'(qy));
    apb_write(sphtu_pkg::REG_SEARCH_RADIUS, 32'(radius));
  endtask

  // one point transaction; the sender may idle between bursts of random length
  task automatic send_point(coord_t x, coord_t y, width_t w, bit is_last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    pt_x <= x;
    pt_y <= y;
    pt_width <= w;
    pt_last <= is_last;
    do @(posedge clk); while (!in_ready);
    predict_point(x, y, w, is_last);
    n_points++;
    burst_left--;
  endtask

  // hold off until every result is back and the evaluator has gone quiet
  task automatic wait_idle();
    in_valid <= 1'b0;
    burst_left = 0;
    while (hit_expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------- stimulus helpers ----------------

  function automatic coord_t pick_coord(coord_t center);
    int unsigned sel;
    int span, off;
    sel = $urandom_range(0, 9);
    if (sel == 0) return coord_t'($urandom);
    if (sel == 1) return $urandom_range(0, 1) ? CMAX : CMIN;
    span = 1 << $urandom_range(1, 21);
    off = $urandom_range(0, 2 * span) - span;
    return coord_t'(center + off);
  endfunction

  function automatic width_t pick_width();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return width_t'($urandom);
    if (sel == 1) return WMAX;
    if (sel == 2) return '0;
    return width_t'($urandom_range(0, (1 << $urandom_range(1, 18)) - 1));
  endfunction

  task automatic run_stroke(int len);
    coord_t qc_x, qc_y;
    width_t w;
    bit vary;
    qc_x = coord_t'(cfg_qx);
    qc_y = coord_t'(cfg_qy);
    w = pick_width();
    vary = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      if (vary) w = pick_width();
      send_point(pick_coord(qc_x), pick_coord(qc_y), w, i == len - 1);
    end
  endtask

  // ---------------- tests ----------------

  // lone-point strokes, including the truncating halving of the width
  task automatic test_single_point();
    set_config('0, '0, '0);
    send_point(0, 0, 0, 1'b1);
    send_point(1, 0, 0, 1'b1);
    send_point(1, 0, 2, 1'b1);
    send_point(2, 0, 3, 1'b1);
    send_point(2, 0, 4, 1'b1);
    wait_idle();
  endtask

  // interior projection, both clamped ends, zero-length segment, width per end point
  task automatic test_segment_geometry();
    set_config('0, '0, 256);
    send_point(-1000, 100, 0, 1'b0);
    send_point(1000, 100, 0, 1'b1);
    send_point(-1000, 300, 0, 1'b0);
    send_point(1000, 300, 0, 1'b1);
    send_point(-1000, 300, 0, 1'b0);
    send_point(1000, 300, 100, 1'b1);
    send_point(500, 0, 0, 1'b0);
    send_point(1000, 0, 0, 1'b1);
    send_point(-1000, 0, 0, 1'b0);
    send_point(-300, 0, 0, 1'b1);
    send_point(200, 0, 0, 1'b0);
    send_point(200, 0, 0, 1'b1);
    send_point(300, 0, 0, 1'b0);
    send_point(300, 0, 0, 1'b1);
    wait_idle();
  endtask

  task automatic test_coordinate_extremes();
    set_config(CMAX, CMIN, WMAX);
    send_point(CMIN, CMAX, WMAX, 1'b0);
    send_point(CMAX, CMAX, 0, 1'b0);
    send_point(CMIN, CMIN, WMAX, 1'b1);
    wait_idle();
    set_config(CMIN, CMIN, '0);
    send_point(CMIN, CMIN, 0, 1'b1);
    send_point(CMAX, CMAX, WMAX, 1'b1);
    wait_idle();
  endtask

  // radius changed while a stroke is open: the closing segment sees the new value
  task automatic test_config_mid_stroke();
    set_config('0, '0, '0);
    send_point(-1000, 50, 0, 1'b0);
    wait_idle();
    apb_write(sphtu_pkg::REG_SEARCH_RADIUS, 32'd100);
    send_point(1000, 50, 0, 1'b1);
    wait_idle();
  endtask

  task automatic test_random_strokes();
    int items, len;
    for (int p = 0; p < 6; p++) begin
      wait_idle();
      case (p)
        0: set_config(CMAX, CMIN, WMAX);
        1: set_config(coord_t'($urandom), coord_t'($urandom), '0);
        default: set_config(coord_t'($urandom), coord_t'($urandom),
                            width_t'($urandom_range(0, (1 << $urandom_range(2, 20)) - 1)));
      endcase
      items = 0;
      while (items < 70) begin
        len = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 8);
        run_stroke(len);
        items += len;
      end
    end
    wait_idle();
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid = 1'b0;
    pt_x = '0;
    pt_y = '0;
    pt_width = '0;
    pt_last = 1'b0;
    rsp_ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cfg_qx = 0;
    cfg_qy = 0;
    cfg_radius = 0;
    prev_px = 0;
    prev_py = 0;
    have_prev = 1'b0;
    hit_acc = 1'b0;
    repeat (3) @(posedge clk);
    rst_ni <= 1'b1;
    @(posedge clk);

    test_single_point();
    test_segment_geometry();
    test_coordinate_extremes();
    test_config_mid_stroke();
    test_random_strokes();

    $display("Covered %0d strokes (%0d points) across %0d register writes, with stalls",
             n_strokes, n_points, n_writes);
    $display("on both streams; %0d results checked: %0d hits, %0d misses.",
             n_results, n_hits, n_results - n_hits);
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
